### src/sddm_pkg.sv
// Package for the smoothed differential drive mixer.
// Holds the microcode types, the control store and the configuration constants.
// No dependencies.
package sddm_pkg;

    // Configuration register map
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned ALPHA_W     = 16;
    localparam int unsigned BAND_W      = 15;
    localparam int unsigned TIMEOUT_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_ALPHA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BAND     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 2'd3;

    localparam logic [ALPHA_W-1:0]   RST_HEADING_ALPHA = 16'd6554;
    localparam logic [ALPHA_W-1:0]   RST_TURN_ALPHA    = 16'd9830;
    localparam logic [BAND_W-1:0]    RST_ZERO_BAND     = 15'd328;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT       = 16'd16;

    // Rounding constant for the Q0.16 smoothing product
    localparam int unsigned ALPHA_HALF = 32768;

    // Microcode
    localparam int unsigned PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [3:0] {
        OP_IDLE,      // wait for a request, latch command and idle count
        OP_TIMEOUT,   // clear targets after too many idle periods
        OP_DIFF,      // magnitude and sign of target minus smoothed value
        OP_MUL,       // magnitude times alpha
        OP_STEP,      // move smoothed value by the rounded step
        OP_BAND,      // snap small smoothed value to zero
        OP_MIX,       // form left and right sides
        OP_MAX,       // larger side magnitude
        OP_NOP,       // no datapath action, only sequencing
        OP_DIVINIT,   // load dividend for one side
        OP_DIVSTEP,   // one restoring division step
        OP_DIVEND,    // write back the signed quotient
        OP_EMIT       // load the output register
    } t_op;

    typedef enum logic [1:0] {
        C_NEXT,       // fall through
        C_ALWAYS,     // jump
        C_CNT_NZ,     // jump while the loop counter is nonzero
        C_NO_NORM     // jump when no normalization is needed
    } t_cond;

    typedef struct packed {
        t_op   op;
        logic  sel;     // 0: heading / left, 1: turn / right
        t_cond cond;
        t_pc   target;
    } t_uword;

    function automatic t_uword mk_uword(input t_op op, input logic sel,
                                        input t_cond cond, input t_pc target);
        t_uword w;
        w.op     = op;
        w.sel    = sel;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store: one word per step
    function automatic t_uword ucode_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            5'd0:    w = mk_uword(OP_IDLE,    1'b0, C_NEXT,    5'd0);
            5'd1:    w = mk_uword(OP_TIMEOUT, 1'b0, C_NEXT,    5'd0);
            5'd2:    w = mk_uword(OP_DIFF,    1'b0, C_NEXT,    5'd0);
            5'd3:    w = mk_uword(OP_MUL,     1'b0, C_NEXT,    5'd0);
            5'd4:    w = mk_uword(OP_STEP,    1'b0, C_NEXT,    5'd0);
            5'd5:    w = mk_uword(OP_BAND,    1'b0, C_NEXT,    5'd0);
            5'd6:    w = mk_uword(OP_DIFF,    1'b1, C_NEXT,    5'd0);
            5'd7:    w = mk_uword(OP_MUL,     1'b1, C_NEXT,    5'd0);
            5'd8:    w = mk_uword(OP_STEP,    1'b1, C_NEXT,    5'd0);
            5'd9:    w = mk_uword(OP_BAND,    1'b1, C_NEXT,    5'd0);
            5'd10:   w = mk_uword(OP_MIX,     1'b0, C_NEXT,    5'd0);
            5'd11:   w = mk_uword(OP_MAX,     1'b0, C_NEXT,    5'd0);
            5'd12:   w = mk_uword(OP_NOP,     1'b0, C_NO_NORM, 5'd19);
            5'd13:   w = mk_uword(OP_DIVINIT, 1'b0, C_NEXT,    5'd0);
            5'd14:   w = mk_uword(OP_DIVSTEP, 1'b0, C_CNT_NZ,  5'd14);
            5'd15:   w = mk_uword(OP_DIVEND,  1'b0, C_NEXT,    5'd0);
            5'd16:   w = mk_uword(OP_DIVINIT, 1'b1, C_NEXT,    5'd0);
            5'd17:   w = mk_uword(OP_DIVSTEP, 1'b1, C_CNT_NZ,  5'd17);
            5'd18:   w = mk_uword(OP_DIVEND,  1'b1, C_NEXT,    5'd0);
            5'd19:   w = mk_uword(OP_EMIT,    1'b0, C_ALWAYS,  5'd0);
            default: w = mk_uword(OP_NOP,     1'b0, C_ALWAYS,  5'd0);
        endcase
        return w;
    endfunction

endpackage

### src/smoothed_differential_drive_mixer_unit.sv
// Smoothed differential drive mixer, top level.
// Microcoded datapath driven by the control store in sddm_pkg.
// Depends on: sddm_pkg.

// One request is one control period. A command period loads new heading and
// turn targets; after timeout_periods periods without one the targets drop to
// zero. Each smoothed value moves toward its target by alpha of the difference
// and snaps to zero inside zero_band, then the two are mixed into left and
// right sides and split into forward and reverse duty. A short program in a
// control store runs the datapath one step per cycle, holding while it waits
// for a request or for the last result to be taken. When a side exceeds full
// scale, both sides are normalized by the bit-serial divider, which takes one
// quotient bit per cycle; otherwise the divider steps are skipped. The next
// request can be accepted right after the result is loaded, while that result
// still waits to be taken.
module smoothed_differential_drive_mixer_unit #(
    parameter int unsigned VALUE_WIDTH = 16,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // Configuration write port
    input  logic                                        i_cfg_we,
    input  logic [sddm_pkg::CFG_IDX_W-1:0]              i_cfg_idx,
    input  logic [sddm_pkg::CFG_DATA_W-1:0]             i_cfg_data,
    // Request stream
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // tdata: heading_command, turn_command (low to high), zero padded
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
    // tuser: command_valid
    input  logic                                        s_axis_tuser,
    // Result stream
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // tdata: left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty
    // (low to high), zero padded
    output logic [((4*VALUE_WIDTH+7)/8)*8-1:0]          m_axis_tdata
);

    localparam int unsigned W      = VALUE_WIDTH;
    localparam int unsigned AW     = sddm_pkg::ALPHA_W;
    localparam int unsigned PW     = W + AW;
    localparam int unsigned BW     = (W + 1 > sddm_pkg::BAND_W) ? W + 1 : sddm_pkg::BAND_W;
    localparam int unsigned IW     = (COUNT_WIDTH > sddm_pkg::TIMEOUT_W) ?
                                     COUNT_WIDTH : sddm_pkg::TIMEOUT_W;
    localparam int unsigned CNT_W  = $clog2(W);
    localparam int unsigned OUT_DW = ((4*VALUE_WIDTH+7)/8)*8;
    localparam logic [W:0]  VAL_ONE   = (W+1)'(1) << (W-1);
    localparam logic [PW-1:0] ROUND_C = PW'(sddm_pkg::ALPHA_HALF);
    localparam logic [COUNT_WIDTH-1:0] IDLE_MAX = '1;

    // Configuration
    logic [sddm_pkg::ALPHA_W-1:0]   r_hd_alpha;
    logic [sddm_pkg::ALPHA_W-1:0]   r_tn_alpha;
    logic [sddm_pkg::BAND_W-1:0]    r_zero_band;
    logic [sddm_pkg::TIMEOUT_W-1:0] r_timeout;

    // Period state
    logic signed [W-1:0]    r_hd_tgt;
    logic signed [W-1:0]    r_tn_tgt;
    logic signed [W-1:0]    r_sm_hd;
    logic signed [W-1:0]    r_sm_tn;
    logic [COUNT_WIDTH-1:0] r_idle;

    // Datapath scratch
    logic [W-1:0]           r_mag;
    logic                   r_neg;
    logic [PW-1:0]          r_prod;
    logic signed [W:0]      r_left;
    logic signed [W:0]      r_right;
    logic [W:0]             r_max;
    logic [W+1:0]           r_rem;
    logic [W-1:0]           r_quo;
    logic [CNT_W-1:0]       r_cnt;

    // Sequencer
    sddm_pkg::t_pc          r_pc;
    sddm_pkg::t_pc          n_pc;
    sddm_pkg::t_uword       uw;

    // Result register
    logic                   r_m_valid;
    logic [W-1:0]           r_l_fwd;
    logic [W-1:0]           r_l_rev;
    logic [W-1:0]           r_r_fwd;
    logic [W-1:0]           r_r_rev;

    // Combinational helpers
    logic                   accept;
    logic                   stall;
    logic                   jump;
    logic signed [W-1:0]    sel_tgt;
    logic signed [W-1:0]    sel_sm;
    logic [AW-1:0]          sel_alpha;
    logic signed [W:0]      diff;
    logic [PW-1:0]          rounded;
    logic [W-1:0]           step_mag;
    logic signed [W:0]      step_sum;
    logic signed [W:0]      sm_ext;
    logic [W:0]             sm_mag;
    logic                   in_band;
    logic signed [W:0]      mix_l;
    logic signed [W:0]      mix_r;
    logic signed [W+1:0]    l_ext;
    logic signed [W+1:0]    r_ext;
    logic [W:0]             mag_l;
    logic [W:0]             mag_r;
    logic signed [W:0]      side;
    logic signed [W+1:0]    side_ext;
    logic [W:0]             side_mag;
    logic [2*W:0]           dividend;
    logic [W+1:0]           trial;
    logic                   q_bit;
    logic signed [W:0]      quo_s;
    logic signed [W:0]      neg_left;
    logic signed [W:0]      neg_right;

    assign uw            = sddm_pkg::ucode_rom(r_pc);
    assign s_axis_tready = (uw.op == sddm_pkg::OP_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Sequencer: hold on a stalled step, else jump or advance
    always_comb begin
        stall = ((uw.op == sddm_pkg::OP_IDLE) && !s_axis_tvalid) ||
                ((uw.op == sddm_pkg::OP_EMIT) && r_m_valid && !m_axis_tready);
        unique case (uw.cond)
            sddm_pkg::C_NEXT:    jump = 1'b0;
            sddm_pkg::C_ALWAYS:  jump = 1'b1;
            sddm_pkg::C_CNT_NZ:  jump = (r_cnt != '0);
            sddm_pkg::C_NO_NORM: jump = (r_max <= VAL_ONE);
            default:             jump = 1'b0;
        endcase
        if (stall) begin
            n_pc = r_pc;
        end else if (jump) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + sddm_pkg::t_pc'(1);
        end
    end

    // Datapath operands
    always_comb begin
        sel_tgt   = uw.sel ? r_tn_tgt : r_hd_tgt;
        sel_sm    = uw.sel ? r_sm_tn : r_sm_hd;
        sel_alpha = uw.sel ? r_tn_alpha : r_hd_alpha;

        // Smoothing
        diff     = (W+1)'(sel_tgt) - (W+1)'(sel_sm);
        rounded  = r_prod + ROUND_C;
        step_mag = rounded[PW-1:AW];
        step_sum = r_neg ? (W+1)'(sel_sm) - $signed({1'b0, step_mag})
                         : (W+1)'(sel_sm) + $signed({1'b0, step_mag});
        sm_ext   = (W+1)'(sel_sm);
        sm_mag   = (sm_ext < 0) ? (W+1)'(0) - sm_ext[W:0] : sm_ext[W:0];
        in_band  = (BW'(sm_mag) < BW'(r_zero_band));

        // Mixing, turn sign swapped in reverse
        if (r_sm_hd >= 0) begin
            mix_l = (W+1)'(r_sm_hd) + (W+1)'(r_sm_tn);
            mix_r = (W+1)'(r_sm_hd) - (W+1)'(r_sm_tn);
        end else begin
            mix_l = (W+1)'(r_sm_hd) - (W+1)'(r_sm_tn);
            mix_r = (W+1)'(r_sm_hd) + (W+1)'(r_sm_tn);
        end
        l_ext = (W+2)'(r_left);
        r_ext = (W+2)'(r_right);
        mag_l = (l_ext < 0) ? (W+1)'(0) - r_left[W:0] : r_left[W:0];
        mag_r = (r_ext < 0) ? (W+1)'(0) - r_right[W:0] : r_right[W:0];

        // Normalization divider
        side     = uw.sel ? r_right : r_left;
        side_ext = (W+2)'(side);
        side_mag = (side_ext < 0) ? (W+1)'(0) - side[W:0] : side[W:0];
        dividend = ((2*W+1)'(side_mag) << (W-1)) + (2*W+1)'(r_max >> 1);
        trial    = {r_rem[W:0], r_quo[W-1]};
        q_bit    = (trial >= (W+2)'(r_max));
        quo_s    = r_neg ? (W+1)'(0) - $signed({1'b0, r_quo})
                         : $signed({1'b0, r_quo});

        // Output split
        neg_left  = (W+1)'(0) - r_left;
        neg_right = (W+1)'(0) - r_right;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd_alpha  <= sddm_pkg::RST_HEADING_ALPHA;
            r_tn_alpha  <= sddm_pkg::RST_TURN_ALPHA;
            r_zero_band <= sddm_pkg::RST_ZERO_BAND;
            r_timeout   <= sddm_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sddm_pkg::CFG_HEADING_ALPHA: r_hd_alpha  <= i_cfg_data[AW-1:0];
                sddm_pkg::CFG_TURN_ALPHA:    r_tn_alpha  <= i_cfg_data[AW-1:0];
                sddm_pkg::CFG_ZERO_BAND:
                    r_zero_band <= i_cfg_data[sddm_pkg::BAND_W-1:0];
                sddm_pkg::CFG_TIMEOUT:
                    r_timeout   <= i_cfg_data[sddm_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if ((uw.op == sddm_pkg::OP_EMIT) && !stall) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Period state: targets, smoothed values, idle count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd_tgt <= '0;
            r_tn_tgt <= '0;
            r_sm_hd  <= '0;
            r_sm_tn  <= '0;
            r_idle   <= '0;
        end else begin
            unique case (uw.op)
                sddm_pkg::OP_IDLE: begin
                    if (accept) begin
                        if (s_axis_tuser) begin
                            r_hd_tgt <= s_axis_tdata[W-1:0];
                            r_tn_tgt <= s_axis_tdata[2*W-1:W];
                            r_idle   <= '0;
                        end else if (r_idle != IDLE_MAX) begin
                            r_idle <= r_idle + COUNT_WIDTH'(1);
                        end
                    end
                end
                sddm_pkg::OP_TIMEOUT: begin
                    if (IW'(r_idle) >= IW'(r_timeout)) begin
                        r_hd_tgt <= '0;
                        r_tn_tgt <= '0;
                    end
                end
                sddm_pkg::OP_STEP: begin
                    if (uw.sel) begin
                        r_sm_tn <= step_sum[W-1:0];
                    end else begin
                        r_sm_hd <= step_sum[W-1:0];
                    end
                end
                sddm_pkg::OP_BAND: begin
                    if (in_band) begin
                        if (uw.sel) begin
                            r_sm_tn <= '0;
                        end else begin
                            r_sm_hd <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Scratch datapath
    always_ff @(posedge i_clk) begin
        unique case (uw.op)
            sddm_pkg::OP_DIFF: begin
                r_neg <= diff[W];
                r_mag <= diff[W] ? W'(0) - diff[W-1:0] : diff[W-1:0];
            end
            sddm_pkg::OP_MUL: begin
                r_prod <= PW'(r_mag) * PW'(sel_alpha);
            end
            sddm_pkg::OP_MIX: begin
                r_left  <= mix_l;
                r_right <= mix_r;
            end
            sddm_pkg::OP_MAX: begin
                r_max <= (mag_l > mag_r) ? mag_l : mag_r;
            end
            sddm_pkg::OP_DIVINIT: begin
                r_neg <= side[W];
                r_rem <= (W+2)'(dividend[2*W:W]);
                r_quo <= dividend[W-1:0];
                r_cnt <= CNT_W'(W-1);
            end
            sddm_pkg::OP_DIVSTEP: begin
                r_rem <= q_bit ? trial - (W+2)'(r_max) : trial;
                r_quo <= {r_quo[W-2:0], q_bit};
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            sddm_pkg::OP_DIVEND: begin
                if (uw.sel) begin
                    r_right <= quo_s;
                end else begin
                    r_left <= quo_s;
                end
            end
            default: ;
        endcase
    end

    // Result register: split each side into forward and reverse duty
    always_ff @(posedge i_clk) begin
        if ((uw.op == sddm_pkg::OP_EMIT) && !stall) begin
            if (r_left >= 0) begin
                r_l_fwd <= r_left[W-1:0];
                r_l_rev <= '0;
            end else begin
                r_l_fwd <= '0;
                r_l_rev <= neg_left[W-1:0];
            end
            if (r_right >= 0) begin
                r_r_fwd <= r_right[W-1:0];
                r_r_rev <= '0;
            end else begin
                r_r_fwd <= '0;
                r_r_rev <= neg_right[W-1:0];
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_DW'({r_r_rev, r_r_fwd, r_l_rev, r_l_fwd});

endmodule
